[rtl/mesh_subnet_bridge_table_top_defines.svh]
// Assertion macros for the subnet bridge table
`ifndef MESH_SUBNET_BRIDGE_TABLE_TOP_DEFINES_SVH
`define MESH_SUBNET_BRIDGE_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSB_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSB_ASSERT(label, clk, rst, prop, msg)
`define MSB_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/msbt_pkg.sv]
// Package: types and codes for the subnet bridge table
`timescale 1ns / 1ps
package msbt_pkg;
   localparam int TableRowsDefault = 16;
   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_LOOKUP = 3'd2;
   localparam logic [2:0] FUNC_KEYDEL = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;
   localparam logic [2:0] FUNC_READ   = 3'd5;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_ARG = 2'd1;
   localparam logic [1:0] ST_BAD_KEY = 2'd2;
   localparam logic [1:0] ST_NO_ROOM = 2'd3;
   localparam logic [1:0] DIR_ONE = 2'd1;
   localparam logic [1:0] DIR_TWO = 2'd2;
   localparam logic [15:0] ADDR_UNASSIGNED = 16'h0000;
   localparam logic [15:0] ADDR_ALL_NODES  = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  direction;
      logic [15:0] net_index_a;
      logic [15:0] net_index_b;
      logic [15:0] address_a;
      logic [15:0] address_b;
      logic        keys_present;
      logic [5:0]  row_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [11:0] target_net_index;
      logic [6:0]  row_count;
      logic        row_valid;
      logic [1:0]  row_direction;
      logic [11:0] row_net_a;
      logic [11:0] row_net_b;
      logic [15:0] row_addr_a;
      logic [15:0] row_addr_b;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  dir;
      logic [11:0] na;
      logic [11:0] nb;
      logic [15:0] aa;
      logic [15:0] ab;
   } row_type;

   function automatic logic is_unicast(input logic [15:0] a);
      return (a != 16'h0) && !a[15];
   endfunction
endpackage

[rtl/msbt_req_if.sv]
// Valid/ready request channel interface
`timescale 1ns / 1ps
interface msbt_req_if import msbt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/msbt_rsp_if.sv]
// Valid/ready response channel interface
`timescale 1ns / 1ps
interface msbt_rsp_if import msbt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/mesh_subnet_bridge_table_top.sv]
// Operation: add/remove/lookup/key-delete walk the rows in use, each row through a read
// state and a compare state; an appending add then passes the write state, and an add
// that finds its row stops there. Each lookup hit also passes the emit state. Clear,
// rejected requests and out-of-range reads go straight to done; a row read reads first.
// Throughput: one operation at a time; the next request waits until the last beat leaves.
// Reset (synchronous) empties the table; row contents stay undefined until written.
`timescale 1ns / 1ps
`include "mesh_subnet_bridge_table_top_defines.svh"
module mesh_subnet_bridge_table_top import msbt_pkg::*; #(
   parameter int TABLE_ROWS = TableRowsDefault
) (
   input logic clock,
   input logic reset,
   msbt_req_if.sink   req,
   msbt_rsp_if.source rsp
);
   localparam int IW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam int CW = $clog2(TABLE_ROWS + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CHECK = 6'b000100,
      S_EMIT  = 6'b001000,
      S_WRITE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   req_type     op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;     // read pointer
   logic [CW-1:0] wr_ff, wr_in;     // compaction write pointer
   logic        found_ff, found_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   row_type     mem [TABLE_ROWS];
   row_type     rdata_ff;
   logic        we;
   logic [IW-1:0] waddr;
   row_type     wdata;

   // one shared row compare unit
   logic fwd, back, dup, kill;
   always_comb begin
      fwd  = (rdata_ff.dir == DIR_ONE || rdata_ff.dir == DIR_TWO) &&
             {4'h0, rdata_ff.na} == op_ff.net_index_a &&
             rdata_ff.aa == op_ff.address_a && rdata_ff.ab == op_ff.address_b;
      back = rdata_ff.dir == DIR_TWO && {4'h0, rdata_ff.nb} == op_ff.net_index_a &&
             rdata_ff.ab == op_ff.address_a && rdata_ff.aa == op_ff.address_b;
      dup  = {4'h0, rdata_ff.na} == op_ff.net_index_a &&
             {4'h0, rdata_ff.nb} == op_ff.net_index_b &&
             rdata_ff.aa == op_ff.address_a && rdata_ff.ab == op_ff.address_b;
      if (op_ff.func == FUNC_KEYDEL)
         kill = {4'h0, rdata_ff.na} == op_ff.net_index_a ||
                {4'h0, rdata_ff.nb} == op_ff.net_index_a;
      else
         kill = {4'h0, rdata_ff.na} == op_ff.net_index_a &&
                {4'h0, rdata_ff.nb} == op_ff.net_index_b &&
                ((rdata_ff.aa == op_ff.address_a && rdata_ff.ab == op_ff.address_b) ||
                 (op_ff.address_b == ADDR_UNASSIGNED && rdata_ff.aa == op_ff.address_a) ||
                 (op_ff.address_a == ADDR_UNASSIGNED && rdata_ff.ab == op_ff.address_b));
   end

   // argument checks
   logic [1:0] add_st, rem_st;
   always_comb begin
      req_type r;
      logic nbad;
      r = req.payload;
      nbad = r.net_index_a == r.net_index_b || r.net_index_a > 16'd4095 ||
             r.net_index_b > 16'd4095;
      add_st = ST_OK;
      if (!is_unicast(r.address_a) || nbad || r.address_a == r.address_b)
         add_st = ST_BAD_ARG;
      else if (r.direction != 8'(DIR_ONE) && r.direction != 8'(DIR_TWO))
         add_st = ST_BAD_ARG;
      else if (r.direction == 8'(DIR_ONE) && (r.address_b == ADDR_UNASSIGNED ||
               r.address_b == ADDR_ALL_NODES))
         add_st = ST_BAD_ARG;
      else if (r.direction == 8'(DIR_TWO) && !is_unicast(r.address_b))
         add_st = ST_BAD_ARG;
      else if (!r.keys_present)
         add_st = ST_BAD_KEY;
      rem_st = ST_OK;
      if ((!is_unicast(r.address_a) && r.address_a != ADDR_UNASSIGNED) ||
          (is_unicast(r.address_a) && r.address_a == r.address_b) ||
          r.address_b == ADDR_ALL_NODES || nbad)
         rem_st = ST_BAD_ARG;
      else if (!r.keys_present)
         rem_st = ST_BAD_KEY;
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      found_in = found_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      we = 1'b0;
      waddr = wr_ff[IW-1:0];
      wdata = rdata_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.payload;
               rd_in = '0;
               wr_in = '0;
               found_in = 1'b0;
               status_in = ST_OK;
               state_in = S_READ;
               case (req.payload.func)
                  FUNC_ADD: begin
                     status_in = add_st;
                     if (add_st != ST_OK) state_in = S_DONE;
                  end
                  FUNC_REMOVE: begin
                     status_in = rem_st;
                     if (rem_st != ST_OK) state_in = S_DONE;
                  end
                  FUNC_LOOKUP, FUNC_KEYDEL: ;
                  FUNC_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  FUNC_READ: begin
                     rd_in = CW'(req.payload.row_index);
                     if ({1'b0, req.payload.row_index} >= 7'(count_ff))
                        state_in = S_DONE;
                  end
                  default: begin
                     status_in = ST_BAD_ARG;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            // memory read issued in clocked block; data ready next cycle
            if (op_ff.func != FUNC_READ && rd_ff >= count_ff)
               state_in = (op_ff.func == FUNC_ADD) ? S_WRITE : S_DONE;
            else
               state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_READ;
            rd_in = rd_ff + 1'b1;
            case (op_ff.func)
               FUNC_ADD: begin
                  if (dup) begin
                     we = 1'b1;
                     waddr = rd_ff[IW-1:0];
                     wdata.dir = op_ff.direction[1:0];
                     state_in = S_DONE;
                  end
               end
               FUNC_LOOKUP: begin
                  if (fwd || back) begin
                     found_in = 1'b1;
                     state_in = S_EMIT;
                  end
               end
               FUNC_READ: state_in = S_DONE;
               default: begin
                  if (!kill) begin
                     we = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
               end
            endcase
         end
         S_EMIT: begin
            // wait until the output is free for the lookup hit beat; last is set at the end
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.hit = 1'b1;
               rsp_in.target_net_index = fwd ? rdata_ff.nb : rdata_ff.na;
               rsp_in.row_count = 7'(count_ff);
               state_in = S_READ;
            end
         end
         S_WRITE: begin
            if (count_ff >= CW'(TABLE_ROWS)) begin
               status_in = ST_NO_ROOM;
            end else begin
               we = 1'b1;
               waddr = count_ff[IW-1:0];
               wdata.dir = op_ff.direction[1:0];
               wdata.na = op_ff.net_index_a[11:0];
               wdata.nb = op_ff.net_index_b[11:0];
               wdata.aa = op_ff.address_a;
               wdata.ab = op_ff.address_b;
               count_in = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.row_count = 7'(count_ff);
               if ((op_ff.func == FUNC_REMOVE && status_ff == ST_OK) ||
                   op_ff.func == FUNC_KEYDEL) begin
                  count_in = wr_ff;
                  rsp_in.row_count = 7'(wr_ff);
               end
               if (op_ff.func == FUNC_LOOKUP && found_ff) begin
                  // the held-back final hit leaves from the pending register below
                  rsp_in = rsp_ff;
                  rsp_in.last = 1'b1;
               end
               if (op_ff.func == FUNC_READ && {1'b0, op_ff.row_index} < 7'(count_ff)) begin
                  rsp_in.row_valid = 1'b1;
                  rsp_in.row_direction = rdata_ff.dir;
                  rsp_in.row_net_a = rdata_ff.na;
                  rsp_in.row_net_b = rdata_ff.nb;
                  rsp_in.row_addr_a = rdata_ff.aa;
                  rsp_in.row_addr_b = rdata_ff.ab;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Lookup hits are held one beat behind so the final one can carry last.
   // pend_ff holds the newest hit until the next hit or the end of the walk.
   logic    pend_ff, pend_in;
   rsp_type pend_rsp_ff, pend_rsp_in;
   logic    out_valid;
   rsp_type out_rsp;
   always_comb begin
      pend_in = pend_ff;
      pend_rsp_in = pend_rsp_ff;
      out_valid = rsp_valid_in;
      out_rsp = rsp_in;
      if (state_ff == S_EMIT && rsp_free) begin
         pend_in = 1'b1;
         pend_rsp_in = rsp_in;
         out_valid = pend_ff || (rsp_valid_ff && !rsp.ready);
         out_rsp = pend_ff ? pend_rsp_ff : rsp_ff;
      end else if (state_ff == S_DONE && rsp_free && op_ff.func == FUNC_LOOKUP) begin
         pend_in = 1'b0;
         out_rsp = found_ff ? pend_rsp_ff : rsp_in;
         out_rsp.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= out_valid;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      rd_ff <= rd_in;
      wr_ff <= wr_in;
      found_ff <= found_in;
      status_ff <= status_in;
      rsp_ff <= out_rsp;
      pend_rsp_ff <= pend_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (state_ff == S_READ) rdata_ff <= mem[rd_ff[IW-1:0]];
   end

   `MSB_ASSERT(a_count_max, clock, reset, count_ff <= CW'(TABLE_ROWS), "row count overflow")
   `MSB_ASSERT(a_ready_idle, clock, reset, req.ready |-> state_ff == S_IDLE, "ready while busy")
   `MSB_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `MSB_ASSERT(a_compact, clock, reset, wr_ff <= rd_ff || state_ff == S_IDLE, "write past read")
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the subnet bridge table
`timescale 1ns / 1ps
module testbench;
   import msbt_pkg::*;

   localparam int Rows = 16;
   localparam int QuietLimit = 4000;
   localparam logic [2:0] FUNC_BAD6 = 3'd6;
   localparam logic [2:0] FUNC_BAD7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   msbt_req_if req ();
   msbt_rsp_if rsp ();

   mesh_subnet_bridge_table_top #(.TABLE_ROWS(Rows)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   // shadow table
   row_type shadow_rows[Rows];
   int      shadow_count;
   rsp_type pending_rsp[$];
   int      errors;
   int      quiet_cycles;
   logic    sending_done;

   typedef struct {
      req_type    beat;
      logic       has_gold;
      rsp_type    gold;
   } stim_row_type;
   stim_row_type stim_table[$];

   function automatic logic unicast(input logic [15:0] a);
      return a != ADDR_UNASSIGNED && !a[15];
   endfunction

   function automatic rsp_type blank_rsp();
      rsp_type r;
      r = '0;
      return r;
   endfunction

   function automatic void drop_rows(input logic kill[Rows]);
      int w;
      w = 0;
      for (int k = 0; k < shadow_count; k++)
         if (!kill[k]) begin
            shadow_rows[w] = shadow_rows[k];
            w++;
         end
      shadow_count = w;
   endfunction

   function automatic logic [1:0] apply_add(input req_type q);
      logic [15:0] n1, n2, a1, a2;
      n1 = q.net_index_a; n2 = q.net_index_b; a1 = q.address_a; a2 = q.address_b;
      if (!unicast(a1) || n1 == n2 || a1 == a2 || n1 > 4095 || n2 > 4095)
         return ST_BAD_ARG;
      if (q.direction != 8'd1 && q.direction != 8'd2) return ST_BAD_ARG;
      if (q.direction == 8'd1 && (a2 == ADDR_UNASSIGNED || a2 == ADDR_ALL_NODES))
         return ST_BAD_ARG;
      if (q.direction == 8'd2 && !unicast(a2)) return ST_BAD_ARG;
      if (!q.keys_present) return ST_BAD_KEY;
      for (int i = 0; i < shadow_count; i++)
         if (shadow_rows[i].na == n1[11:0] && shadow_rows[i].nb == n2[11:0] &&
             shadow_rows[i].aa == a1 && shadow_rows[i].ab == a2) begin
            shadow_rows[i].dir = q.direction[1:0];
            return ST_OK;
         end
      if (shadow_count >= Rows) return ST_NO_ROOM;
      shadow_rows[shadow_count] = '{q.direction[1:0], n1[11:0], n2[11:0], a1, a2};
      shadow_count++;
      return ST_OK;
   endfunction

   function automatic logic [1:0] apply_remove(input req_type q);
      logic [15:0] n1, n2, a1, a2;
      logic kill[Rows];
      n1 = q.net_index_a; n2 = q.net_index_b; a1 = q.address_a; a2 = q.address_b;
      if ((!unicast(a1) && a1 != ADDR_UNASSIGNED) || (unicast(a1) && a1 == a2) ||
          a2 == ADDR_ALL_NODES)
         return ST_BAD_ARG;
      if (n1 == n2 || n1 > 4095 || n2 > 4095) return ST_BAD_ARG;
      if (!q.keys_present) return ST_BAD_KEY;
      for (int i = 0; i < Rows; i++) begin
         kill[i] = 1'b0;
         if (i < shadow_count && shadow_rows[i].na == n1[11:0] &&
             shadow_rows[i].nb == n2[11:0])
            kill[i] = (shadow_rows[i].aa == a1 && shadow_rows[i].ab == a2) ||
                      (a2 == ADDR_UNASSIGNED && shadow_rows[i].aa == a1) ||
                      (a1 == ADDR_UNASSIGNED && shadow_rows[i].ab == a2);
      end
      drop_rows(kill);
      return ST_OK;
   endfunction

   // updates the shadow table and queues the beats the request should produce
   function automatic void predict_bridge(input req_type q);
      rsp_type r;
      logic kill[Rows];
      logic fwd, back;
      int hits;
      if (q.func == FUNC_LOOKUP) begin
         hits = 0;
         for (int i = 0; i < shadow_count; i++) begin
            fwd = (shadow_rows[i].dir == DIR_ONE || shadow_rows[i].dir == DIR_TWO) &&
                  {4'd0, shadow_rows[i].na} == q.net_index_a &&
                  shadow_rows[i].aa == q.address_a && shadow_rows[i].ab == q.address_b;
            back = shadow_rows[i].dir == DIR_TWO &&
                   {4'd0, shadow_rows[i].nb} == q.net_index_a &&
                   shadow_rows[i].ab == q.address_a && shadow_rows[i].aa == q.address_b;
            if (fwd || back) begin
               r = blank_rsp();
               r.hit = 1'b1;
               r.target_net_index = fwd ? shadow_rows[i].nb : shadow_rows[i].na;
               r.row_count = 7'(shadow_count);
               pending_rsp.push_back(r);
               hits++;
            end
         end
         if (hits == 0) begin
            r = blank_rsp();
            r.row_count = 7'(shadow_count);
            pending_rsp.push_back(r);
         end
         pending_rsp[$].last = 1'b1;
         return;
      end
      r = blank_rsp();
      case (q.func)
         FUNC_ADD: r.status = apply_add(q);
         FUNC_REMOVE: r.status = apply_remove(q);
         FUNC_KEYDEL: begin
            for (int i = 0; i < Rows; i++)
               kill[i] = i < shadow_count &&
                         ({4'd0, shadow_rows[i].na} == q.net_index_a ||
                          {4'd0, shadow_rows[i].nb} == q.net_index_a);
            drop_rows(kill);
         end
         FUNC_CLEAR: shadow_count = 0;
         FUNC_READ:
            if (q.row_index < shadow_count) begin
               r.row_valid = 1'b1;
               r.row_direction = shadow_rows[q.row_index].dir;
               r.row_net_a = shadow_rows[q.row_index].na;
               r.row_net_b = shadow_rows[q.row_index].nb;
               r.row_addr_a = shadow_rows[q.row_index].aa;
               r.row_addr_b = shadow_rows[q.row_index].ab;
            end
         default: r.status = ST_BAD_ARG;
      endcase
      r.row_count = 7'(shadow_count);
      r.last = 1'b1;
      pending_rsp.push_back(r);
   endfunction

   function automatic req_type make_req(input logic [2:0] f, input logic [7:0] d,
                                        input logic [15:0] na, input logic [15:0] nb,
                                        input logic [15:0] aa, input logic [15:0] ab,
                                        input logic keys, input logic [5:0] idx);
      req_type q;
      q = '{f, d, na, nb, aa, ab, keys, idx};
      return q;
   endfunction

   function automatic rsp_type status_rsp(input logic [1:0] st, input int cnt);
      rsp_type r;
      r = blank_rsp();
      r.status = st;
      r.row_count = 7'(cnt);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input req_type q, input logic g, input rsp_type r);
      stim_row_type s;
      s.beat = q; s.has_gold = g; s.gold = r;
      stim_table.push_back(s);
   endfunction

   // random request; mostly well-formed with small value pools so rows collide
   function automatic req_type rand_req();
      req_type q;
      logic [15:0] pool_net[4], pool_addr[4];
      int pick;
      pool_net = '{16'd0, 16'd1, 16'd4095, 16'd7};
      pool_addr = '{16'h0001, 16'h7FFF, 16'h0002, 16'h0123};
      q = make_req(3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 1'($urandom), 6'($urandom));
      if ($urandom_range(0, 9) < 8) begin
         pick = $urandom_range(0, 99);
         q.func = pick < 40 ? FUNC_ADD : pick < 55 ? FUNC_REMOVE :
                  pick < 78 ? FUNC_LOOKUP : pick < 84 ? FUNC_KEYDEL :
                  pick < 86 ? FUNC_CLEAR : FUNC_READ;
         q.direction = 8'($urandom_range(1, 2));
         q.net_index_a = pool_net[$urandom_range(0, 3)];
         q.net_index_b = pool_net[$urandom_range(0, 3)];
         q.address_a = pool_addr[$urandom_range(0, 3)];
         q.address_b = pool_addr[$urandom_range(0, 3)];
         if (q.func == FUNC_REMOVE && $urandom_range(0, 3) == 0)
            if ($urandom_range(0, 1)) q.address_a = ADDR_UNASSIGNED;
            else q.address_b = ADDR_UNASSIGNED;
         q.keys_present = $urandom_range(0, 15) != 0;
         q.row_index = 6'($urandom_range(0, 18));
      end
      return q;
   endfunction

   initial begin
      req_type q;
      req.valid = 1'b0;
      req.payload = '0;
      sending_done = 1'b0;
      // directed rows
      add_row(make_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 6'd0), 1, status_rsp(ST_OK, 0));
      add_row(make_req(FUNC_LOOKUP, 0, 16'd1, 0, 16'd1, 16'd2, 0, 0), 1,
              status_rsp(ST_OK, 0));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd1, 16'd2, 16'h8001, 16'd2, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd3, 16'd3, 16'd1, 16'd2, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd1, 16'd2, 16'd5, 16'd5, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd4096, 16'd2, 16'd1, 16'd2, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd3, 16'd1, 16'd2, 16'd1, 16'd2, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd1, 16'd2, 16'd1, ADDR_ALL_NODES, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd2, 16'd1, 16'd2, 16'd1, 16'hC000, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 0));
      add_row(make_req(FUNC_ADD, 8'd2, 16'd1, 16'd2, 16'd1, 16'd2, 0, 0), 1,
              status_rsp(ST_BAD_KEY, 0));
      add_row(make_req(FUNC_ADD, 8'd2, 16'd0, 16'd4095, 16'h7FFF, 16'd1, 1, 0), 1,
              status_rsp(ST_OK, 1));
      add_row(make_req(FUNC_ADD, 8'd1, 16'd4095, 16'd0, 16'd1, 16'hC001, 1, 0), 1,
              status_rsp(ST_OK, 2));
      add_row(make_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 6'd0), 0, blank_rsp());
      add_row(make_req(FUNC_LOOKUP, 0, 16'd4095, 0, 16'd1, 16'h7FFF, 0, 0), 0,
              blank_rsp());
      add_row(make_req(FUNC_ADD, 8'd1, 16'd0, 16'd4095, 16'h7FFF, 16'd1, 1, 0), 1,
              status_rsp(ST_OK, 2));
      add_row(make_req(FUNC_REMOVE, 0, 16'd0, 16'd4095, 16'h8000, 16'd1, 1, 0), 1,
              status_rsp(ST_BAD_ARG, 2));
      add_row(make_req(FUNC_REMOVE, 0, 16'd0, 16'd4095, 16'd1, ADDR_ALL_NODES, 1, 0),
              1, status_rsp(ST_BAD_ARG, 2));
      add_row(make_req(FUNC_REMOVE, 0, 16'd0, 16'd4095, 0, 16'd1, 0, 0), 1,
              status_rsp(ST_BAD_KEY, 2));
      add_row(make_req(FUNC_REMOVE, 0, 16'd0, 16'd4095, 0, 16'd1, 1, 0), 0, blank_rsp());
      add_row(make_req(FUNC_KEYDEL, 0, 16'd4095, 0, 0, 0, 0, 0), 0, blank_rsp());
      add_row(make_req(FUNC_BAD6, 0, 0, 0, 0, 0, 0, 0), 0, blank_rsp());
      add_row(make_req(FUNC_BAD7, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                       6'd63), 0, blank_rsp());
      for (int i = 0; i < 17; i++)
         add_row(make_req(FUNC_ADD, 8'd1, 16'd5, 16'd6, 16'(i + 1), 16'd100, 1, 0),
                 i == 16, status_rsp(ST_NO_ROOM, 16));
      add_row(make_req(FUNC_READ, 0, 0, 0, 0, 0, 0, 6'd63), 1, status_rsp(ST_OK, 16));
      add_row(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, status_rsp(ST_OK, 0));

      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      foreach (stim_table[k]) begin
         q = stim_table[k].beat;
         send_beat(q, stim_table[k].has_gold, stim_table[k].gold);
      end
      for (int n = 0; n < 370; n++) begin
         if (n == 200)
            while (pending_rsp.size() != 0) @(negedge clock);
         send_beat(rand_req(), 1'b0, blank_rsp());
      end
      sending_done = 1'b1;
   end

   // checked rows compare the typed-in beat against the prediction too
   task automatic send_beat(input req_type q, input logic has_gold, input rsp_type gold);
      repeat ($urandom_range(0, 13)) @(negedge clock);
      req.payload = q;
      req.valid = 1'b1;
      do @(posedge clock); while (!req.ready);
      predict_bridge(q);
      if (has_gold && pending_rsp[$] !== gold) begin
         $error("directed row: expected %h, predicted %h", gold, pending_rsp[$]);
         errors++;
      end
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // sink stall
   int stall_left;
   initial begin
      rsp.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp.ready = 1'b0;
            stall_left--;
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, exp_rsp;
      if (!reset && rsp.valid && rsp.ready) begin
         stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
         got = rsp.payload;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (got.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, got.status); errors++; end
            if (got.hit !== exp_rsp.hit) begin
               $error("hit exp %0d got %0d", exp_rsp.hit, got.hit); errors++; end
            if (got.target_net_index !== exp_rsp.target_net_index) begin
               $error("target_net_index exp %0d got %0d", exp_rsp.target_net_index,
                      got.target_net_index); errors++; end
            if (got.row_count !== exp_rsp.row_count) begin
               $error("row_count exp %0d got %0d", exp_rsp.row_count, got.row_count);
               errors++; end
            if (got.row_valid !== exp_rsp.row_valid) begin
               $error("row_valid exp %0d got %0d", exp_rsp.row_valid, got.row_valid);
               errors++; end
            if (got.row_direction !== exp_rsp.row_direction) begin
               $error("row_direction exp %0d got %0d", exp_rsp.row_direction,
                      got.row_direction); errors++; end
            if (got.row_net_a !== exp_rsp.row_net_a) begin
               $error("row_net_a exp %0d got %0d", exp_rsp.row_net_a, got.row_net_a);
               errors++; end
            if (got.row_net_b !== exp_rsp.row_net_b) begin
               $error("row_net_b exp %0d got %0d", exp_rsp.row_net_b, got.row_net_b);
               errors++; end
            if (got.row_addr_a !== exp_rsp.row_addr_a) begin
               $error("row_addr_a exp %h got %h", exp_rsp.row_addr_a, got.row_addr_a);
               errors++; end
            if (got.row_addr_b !== exp_rsp.row_addr_b) begin
               $error("row_addr_b exp %h got %h", exp_rsp.row_addr_b, got.row_addr_b);
               errors++; end
            if (got.last !== exp_rsp.last) begin
               $error("last exp %0d got %0d", exp_rsp.last, got.last); errors++; end
         end
      end
   end

   // watchdog and end of run
   initial begin
      errors = 0;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("== FAIL ==");
            $finish;
         end
         if (sending_done && pending_rsp.size() == 0) begin
            repeat (60) @(posedge clock);
            if (errors == 0 && pending_rsp.size() == 0) $display("== PASS ==");
            else $display("== FAIL ==");
            $finish;
         end
      end
   end
endmodule
